@@ rtl/dcba_pkg.sv @@
// Shared types and constants for the dual-channel block average dB block.
// Holds the dB step table, the detect mode codes and the queue status struct.
// No dependencies.
package dcba_pkg;

   localparam int NUM_STEPS = 40;   // one step per dB above the 60 dB base
   localparam int STEP_DIV  = 40;   // mean is divided by this to give k
   localparam int DB_W      = 7;

   typedef logic [DB_W-1:0]      db_type;
   typedef logic [NUM_STEPS-1:0] therm_type;

   localparam db_type DB_BASE = 7'd60;
   localparam db_type DB_ZERO = 7'd0;

   // smallest k with trunc(20*log10(k)) >= d, for d = 1..40
   localparam logic [6:0] STEP_K [NUM_STEPS] = '{
      7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,  7'd3,  7'd4,
      7'd4,  7'd4,  7'd5,  7'd6,  7'd6,  7'd7,  7'd8,  7'd8,  7'd9,  7'd10,
      7'd12, 7'd13, 7'd15, 7'd16, 7'd18, 7'd20, 7'd23, 7'd26, 7'd29, 7'd32,
      7'd36, 7'd40, 7'd45, 7'd51, 7'd57, 7'd64, 7'd71, 7'd80, 7'd90, 7'd100
   };

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_ONE  = 2'd1,
      MODE_TWO  = 2'd2,
      MODE_MAX  = 2'd3
   } mode_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ rtl/dcba_front.sv @@
// Front end: accepts sample pairs and accumulates both channel sums.
// Pushes the finished block sums into the queue. Uses dcba_pkg.
module dcba_front #(
   parameter int BLOCK_LEN   = 32,
   parameter int SAMPLE_BITS = 12,
   parameter int SUM_W       = SAMPLE_BITS + $clog2(BLOCK_LEN)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample_one,
   input  logic [SAMPLE_BITS-1:0]   req_sample_two,
   input  dcba_pkg::q_status_type   q_status,
   output logic                     push,
   output logic [SUM_W-1:0]         push_one,
   output logic [SUM_W-1:0]         push_two
);
   import dcba_pkg::*;

   localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_one_ff, sum_one_in;
   logic [SUM_W-1:0] sum_two_ff, sum_two_in;
   logic             last;
   logic             accept;

   // only the item that closes a block needs room in the queue
   assign last      = (count_ff == CNT_W'(BLOCK_LEN - 1));
   assign req_stall = q_status.full && last;
   assign accept    = req_valid && !req_stall;

   assign push_one = sum_one_ff + SUM_W'(req_sample_one);
   assign push_two = sum_two_ff + SUM_W'(req_sample_two);
   assign push     = accept && last;

   // accumulate, clear at block end
   always_comb begin
      count_in   = count_ff;
      sum_one_in = sum_one_ff;
      sum_two_in = sum_two_ff;
      if (accept) begin
         if (last) begin
            count_in   = '0;
            sum_one_in = '0;
            sum_two_in = '0;
         end else begin
            count_in   = count_ff + CNT_W'(1);
            sum_one_in = push_one;
            sum_two_in = push_two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_one_ff <= '0;
         sum_two_ff <= '0;
      end else begin
         count_ff   <= count_in;
         sum_one_ff <= sum_one_in;
         sum_two_ff <= sum_two_in;
      end
   end

   // a push never meets a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("front pushed into a full queue");

endmodule

@@ rtl/dcba_queue.sv @@
// Two-entry queue carrying block sum pairs from front to back end.
// Uses dcba_pkg for the status struct.
module dcba_queue #(
   parameter int WIDTH = 34
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output dcba_pkg::q_status_type status
);
   import dcba_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill count stays in range
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue fill count out of range");

   // pointers differ exactly when one item is held
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/dcba_back.sv @@
// Back end: turns block sums into dB levels in two stages and holds the result.
// Stage A compares sums against scaled step thresholds, stage B counts and selects.
// Uses dcba_pkg.
module dcba_back #(
   parameter int BLOCK_LEN = 32,
   parameter int SUM_W     = 17
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dcba_pkg::q_status_type q_status,
   input  logic [SUM_W-1:0]       q_sum_one,
   input  logic [SUM_W-1:0]       q_sum_two,
   output logic                   pop,
   input  dcba_pkg::mode_type     mode,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dcba_pkg::db_type       rsp_level_db,
   output dcba_pkg::db_type       rsp_channel_one_db,
   output dcba_pkg::db_type       rsp_channel_two_db,
   output logic                   rsp_channel_one_low,
   output logic                   rsp_channel_two_low
);
   import dcba_pkg::*;

   // k >= t exactly when sum >= t * BLOCK_LEN * 40
   localparam logic [31:0] BLOCK_DIV = 32'(BLOCK_LEN * STEP_DIV);

   therm_type therm_one, therm_two;
   logic      low_one, low_two;

   logic      a_vld_ff;
   therm_type a_therm_one_ff, a_therm_two_ff;
   logic      a_low_one_ff, a_low_two_ff;

   logic      b_vld_ff;
   logic      a_load, b_load, b_take;
   db_type    db_one, db_two, level;

   // threshold compares, one per step
   always_comb begin
      for (int i = 0; i < NUM_STEPS; i++) begin
         therm_one[i] = (32'(q_sum_one) >= 32'(STEP_K[i]) * BLOCK_DIV);
         therm_two[i] = (32'(q_sum_two) >= 32'(STEP_K[i]) * BLOCK_DIV);
      end
      low_one = (32'(q_sum_one) < BLOCK_DIV);
      low_two = (32'(q_sum_two) < BLOCK_DIV);
   end

   // pipeline flow control
   assign b_take = b_vld_ff && !rsp_stall;
   assign b_load = a_vld_ff && (!b_vld_ff || b_take);
   assign a_load = !q_status.empty && (!a_vld_ff || b_load);
   assign pop    = a_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (a_load) begin
            a_vld_ff <= 1'b1;
         end else if (b_load) begin
            a_vld_ff <= 1'b0;
         end
         if (b_load) begin
            b_vld_ff <= 1'b1;
         end else if (b_take) begin
            b_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_therm_one_ff <= therm_one;
         a_therm_two_ff <= therm_two;
         a_low_one_ff   <= low_one;
         a_low_two_ff   <= low_two;
      end
   end

   // level = 60 + steps passed, zero below the floor
   always_comb begin
      db_one = a_low_one_ff ? DB_ZERO : DB_BASE + DB_W'($countones(a_therm_one_ff));
      db_two = a_low_two_ff ? DB_ZERO : DB_BASE + DB_W'($countones(a_therm_two_ff));
      unique case (mode)
         MODE_NONE: level = DB_ZERO;
         MODE_ONE:  level = db_one;
         MODE_TWO:  level = db_two;
         MODE_MAX:  level = (db_one > db_two) ? db_one : db_two;
         default:   level = DB_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         rsp_level_db        <= level;
         rsp_channel_one_db  <= db_one;
         rsp_channel_two_db  <= db_two;
         rsp_channel_one_low <= a_low_one_ff;
         rsp_channel_two_low <= a_low_two_ff;
      end
   end

   assign rsp_valid = b_vld_ff;

   // a low channel reports zero dB
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_channel_one_low) |-> (rsp_channel_one_db == DB_ZERO))
      else $error("channel one low but level nonzero");

   // stage A holds while stage B is blocked
   assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && b_vld_ff && rsp_stall) |=> a_vld_ff)
      else $error("stage A item dropped while blocked");

   // a result that passes the floor sits between 60 and 100 dB
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_channel_two_low) |->
      (rsp_channel_two_db >= DB_BASE && rsp_channel_two_db <= 7'd100))
      else $error("channel two level out of range");

endmodule

@@ rtl/dual_channel_block_average_db.sv @@
// Dual-channel block average with dB conversion: top level, holds the mode register.
// A block's sums go through the two-entry queue, then the stage A and stage B registers.
// Throughput: one sample pair per cycle while req_stall is low; one result per BLOCK_LEN
// pairs, set by the front accumulator, with a two-stage compare/count back end.
// Reset (synchronous, active high) clears the sums, the pair count, the queue, the
// pipeline valids and the detect mode; no clearing pass is needed.
module dual_channel_block_average_db #(
   parameter int BLOCK_LEN   = 32,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_one,
   input  logic [SAMPLE_BITS-1:0] req_sample_two,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dcba_pkg::db_type       rsp_level_db,
   output dcba_pkg::db_type       rsp_channel_one_db,
   output dcba_pkg::db_type       rsp_channel_two_db,
   output logic                   rsp_channel_one_low,
   output logic                   rsp_channel_two_low,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_data
);
   import dcba_pkg::*;

   localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_LEN);

   mode_type         mode_ff, mode_in;
   q_status_type     q_status;
   logic             push, pop;
   logic [SUM_W-1:0] push_one, push_two;
   logic [SUM_W-1:0] q_sum_one, q_sum_two;

   // detect mode register
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? mode_type'(csr_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   dcba_front #(
      .BLOCK_LEN   (BLOCK_LEN),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_one (req_sample_one),
      .req_sample_two (req_sample_two),
      .q_status       (q_status),
      .push           (push),
      .push_one       (push_one),
      .push_two       (push_two)
   );

   dcba_queue #(
      .WIDTH (2 * SUM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_one, push_two}),
      .pop       (pop),
      .pop_data  ({q_sum_one, q_sum_two}),
      .status    (q_status)
   );

   dcba_back #(
      .BLOCK_LEN (BLOCK_LEN),
      .SUM_W     (SUM_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .q_sum_one           (q_sum_one),
      .q_sum_two           (q_sum_two),
      .pop                 (pop),
      .mode                (mode_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_level_db        (rsp_level_db),
      .rsp_channel_one_db  (rsp_channel_one_db),
      .rsp_channel_two_db  (rsp_channel_two_db),
      .rsp_channel_one_low (rsp_channel_one_low),
      .rsp_channel_two_low (rsp_channel_two_low)
   );

endmodule

@@ bench/tb_dual_channel_block_average_db.sv @@
// Self-checking bench for dual_channel_block_average_db: directed, random, hold-off blocks.
// Predicts each block's dB levels and flags from its own sums and threshold table.
// Depends on rtl/dcba_pkg.sv and rtl/dual_channel_block_average_db.sv.
module tb_dual_channel_block_average_db;
   timeunit 1ns;
   timeprecision 1ps;

   import dcba_pkg::*;

   localparam int PAIRS_PER_BLOCK = 32;
   localparam int SAMPLE_W        = 12;
   localparam int K_DIV           = 40;
   localparam int LEVEL_BASE      = 60;
   localparam int LEVEL_CAP       = 100;
   localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;

   // smallest k that reaches each whole dB step above the base level
   localparam int unsigned LEVEL_STEP_K [40] = '{
      2,  2,  2,  2,  2,  2,  3,  3,  3,  4,
      4,  4,  5,  6,  6,  7,  8,  8,  9,  10,
      12, 13, 15, 16, 18, 20, 23, 26, 29, 32,
      36, 40, 45, 51, 57, 64, 71, 80, 90, 100
   };

   typedef struct packed {
      db_type level;
      db_type db_one;
      db_type db_two;
      logic   low_one;
      logic   low_two;
   } block_level_type;

   typedef struct {
      mode_type         mode;
      logic [11:0]      s1;
      logic [11:0]      s2;
      bit               typed;
      block_level_type  level;
   } block_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_one = '0;
   logic [SAMPLE_W-1:0] req_sample_two = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   db_type              rsp_level_db;
   db_type              rsp_channel_one_db;
   db_type              rsp_channel_two_db;
   logic                rsp_channel_one_low;
   logic                rsp_channel_two_low;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_data = '0;

   // predictor state
   logic [16:0]         sum_one_acc;
   logic [16:0]         sum_two_acc;
   int                  pairs_in_block;
   mode_type            mode_shadow;
   block_level_type     pending_levels [$];

   int                  errors;
   int                  pairs_sent;
   int                  blocks_seen;
   int                  send_idle_pct;
   int                  stall_pct;
   bit                  hold_off;

   // each constant block of samples, modes in the order they are written
   block_row_type directed_rows [11] = '{
      '{MODE_NONE, 12'd0,    12'd0,    1'b1, '{7'd0,   7'd0,   7'd0,   1'b1, 1'b1}},
      '{MODE_ONE,  12'd4095, 12'd4095, 1'b1, '{7'd100, 7'd100, 7'd100, 1'b0, 1'b0}},
      '{MODE_TWO,  12'd39,   12'd40,   1'b1, '{7'd60,  7'd0,   7'd60,  1'b1, 1'b0}},
      '{MODE_MAX,  12'd4095, 12'd0,    1'b1, '{7'd100, 7'd100, 7'd0,   1'b0, 1'b1}},
      '{MODE_MAX,  12'd0,    12'd4095, 1'b1, '{7'd100, 7'd0,   7'd100, 1'b1, 1'b0}},
      '{MODE_MAX,  12'd1000, 12'd1000, 1'b0, '0},
      '{MODE_ONE,  12'd80,   12'd1600, 1'b0, '0},
      '{MODE_TWO,  12'hAAA,  12'h555,  1'b0, '0},
      '{MODE_MAX,  12'h555,  12'hAAA,  1'b0, '0},
      '{MODE_NONE, 12'd3000, 12'd200,  1'b0, '0},
      '{MODE_MAX,  12'd120,  12'd119,  1'b0, '0}
   };

   dual_channel_block_average_db dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_one      (req_sample_one),
      .req_sample_two      (req_sample_two),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_level_db        (rsp_level_db),
      .rsp_channel_one_db  (rsp_channel_one_db),
      .rsp_channel_two_db  (rsp_channel_two_db),
      .rsp_channel_one_low (rsp_channel_one_low),
      .rsp_channel_two_low (rsp_channel_two_low),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // block sum to whole dB; low set when the mean is below K_DIV
   function automatic db_type sum_to_db(input logic [16:0] sum, output logic low);
      int unsigned k;
      int unsigned db;
      k = (int'(sum) / PAIRS_PER_BLOCK) / K_DIV;
      low = (k == 0);
      if (k == 0) return '0;
      db = LEVEL_BASE;
      foreach (LEVEL_STEP_K[i])
         if (LEVEL_STEP_K[i] <= k) db++;
      if (db > LEVEL_CAP) db = LEVEL_CAP;
      return db_type'(db);
   endfunction

   // add one accepted pair; returns 1 with the block's levels when it closes a block
   function automatic bit accumulate_pair(input logic [11:0] a, input logic [11:0] b,
                                          output block_level_type res);
      sum_one_acc += 17'(a);
      sum_two_acc += 17'(b);
      pairs_in_block++;
      res = '0;
      if (pairs_in_block < PAIRS_PER_BLOCK) return 1'b0;
      res.db_one = sum_to_db(sum_one_acc, res.low_one);
      res.db_two = sum_to_db(sum_two_acc, res.low_two);
      case (mode_shadow)
         MODE_ONE: res.level = res.db_one;
         MODE_TWO: res.level = res.db_two;
         MODE_MAX: res.level = (res.db_one > res.db_two) ? res.db_one : res.db_two;
         default:  res.level = '0;
      endcase
      sum_one_acc = '0;
      sum_two_acc = '0;
      pairs_in_block = 0;
      return 1'b1;
   endfunction

   // offer one pair, with optional idle cycles first, and wait for acceptance
   task automatic send_pair(input logic [11:0] a, input logic [11:0] b,
                            input bit typed, input block_level_type typed_level);
      block_level_type res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_sample_one <= a;
      req_sample_two <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pairs_sent++;
      if (accumulate_pair(a, b, res))
         pending_levels.push_back(typed ? typed_level : res);
   endtask

   // random block: full-range noise, or two noisy levels (equal in one style) over many decades
   task automatic send_random_block();
      int  style;
      int  center_one;
      int  center_two;
      int  v1;
      int  v2;
      style = $urandom_range(3);
      center_one = $urandom_range(SAMPLE_MAX) >> $urandom_range(11);
      center_two = (style == 3) ? center_one : ($urandom_range(SAMPLE_MAX) >> $urandom_range(11));
      for (int i = 0; i < PAIRS_PER_BLOCK; i++) begin
         if (style == 0) begin
            v1 = $urandom_range(SAMPLE_MAX);
            v2 = $urandom_range(SAMPLE_MAX);
         end else begin
            v1 = center_one + $urandom_range(16) - 8;
            v2 = center_two + $urandom_range(16) - 8;
            v1 = (v1 < 0) ? 0 : (v1 > SAMPLE_MAX) ? SAMPLE_MAX : v1;
            v2 = (v2 < 0) ? 0 : (v2 > SAMPLE_MAX) ? SAMPLE_MAX : v2;
         end
         send_pair(v1[11:0], v2[11:0], 1'b0, '0);
      end
   endtask

   // hold the input side until every predicted result is out, plus pipeline slack
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      mode_shadow = m;
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // result side: check accepted results, then pick next cycle's stall
   always @(posedge clock) begin
      block_level_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         blocks_seen++;
         if (pending_levels.size() == 0) begin
            errors++;
            $display("%0t ns: result with no block pending, level %0d", $time, rsp_level_db);
         end else begin
            want = pending_levels.pop_front();
            check_field("level_db",        want.level,   rsp_level_db);
            check_field("channel_one_db",  want.db_one,  rsp_channel_one_db);
            check_field("channel_two_db",  want.db_two,  rsp_channel_two_db);
            check_field("channel_one_low", want.low_one, rsp_channel_one_low);
            check_field("channel_two_low", want.low_two, rsp_channel_two_low);
         end
      end
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAIL dual_channel_block_average_db");
      $finish;
   end

   initial begin
      int idle_mix  [4];
      int stall_mix [4];
      int spins;
      idle_mix  = '{0, 67, 0, 28};
      stall_mix = '{0, 0, 67, 28};
      errors = 0;
      pairs_sent = 0;
      blocks_seen = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b0;
      sum_one_acc = '0;
      sum_two_acc = '0;
      pairs_in_block = 0;
      mode_shadow = MODE_NONE;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed blocks: extremes, floor, every mode, tie
      foreach (directed_rows[r]) begin
         if (r != 0 || directed_rows[r].mode != MODE_NONE) begin
            wait_results_drained();
            write_mode(directed_rows[r].mode);
         end
         for (int i = 0; i < PAIRS_PER_BLOCK; i++)
            send_pair(directed_rows[r].s1, directed_rows[r].s2,
                      directed_rows[r].typed, directed_rows[r].level);
      end

      // random blocks under each idle/stall mix, new mode for every block
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p];
         stall_pct     = stall_mix[p];
         for (int c = 0; c < 2; c++) begin
            wait_results_drained();
            write_mode(mode_type'($urandom_range(3)));
            send_random_block();
         end
      end

      // long output hold-off while the input keeps pushing, so the block backs up
      wait_results_drained();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_mode(MODE_MAX);
      fork
         begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
         repeat (6) send_random_block();
      join

      // drain with a bound, then watch for stray results
      req_valid <= 1'b0;
      spins = 0;
      while (pending_levels.size() != 0 && spins < 20000) begin
         @(posedge clock);
         spins++;
      end
      repeat (10) @(posedge clock);
      if (pending_levels.size() != 0) begin
         errors += pending_levels.size();
         $display("%0t ns: %0d block results never arrived", $time, pending_levels.size());
      end

      $display("Ran %0d sample pairs, %0d block results checked, over all detect modes,",
               pairs_sent, blocks_seen);
      $display("floor and full-scale blocks, idle/stall mixes and a long output hold-off.");
      if (errors == 0) begin
         $display("PASS dual_channel_block_average_db");
      end else begin
         $display("FAIL dual_channel_block_average_db");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dcba_pkg.sv
rtl/dcba_front.sv
rtl/dcba_queue.sv
rtl/dcba_back.sv
rtl/dual_channel_block_average_db.sv
bench/tb_dual_channel_block_average_db.sv
